>>> rtl/mqpd_pkg.sv
// Shared types, codes and default sizes for the multi-queue priority deque.
package mqpd_pkg;

    // Default sizes
    localparam int NUM_QUEUES_DEF  = 20;
    localparam int QUEUE_DEPTH_DEF = 5;
    localparam int ID_BITS_DEF     = 16;

    // Request codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_TAKEN = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Result control handed from the queue controller through the access stage to the result stage
    typedef struct packed {
        logic [1:0] status;
        logic       taken;
    } mqpd_res_t;

endpackage

>>> rtl/mqpd_ram.sv
// Generic single-port RAM with registered read data.
module mqpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry; read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mqpd_ctrl.sv
// Queue controller: head and fill count per queue, slot selection and entry access.
module mqpd_ctrl #(
    parameter int NUM_QUEUES  = mqpd_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqpd_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = mqpd_pkg::ID_BITS_DEF,
    localparam int QI_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int ENT_W  = ID_BITS + 1,
    localparam int ADDR_W = (NUM_QUEUES * QUEUE_DEPTH > 1) ?
                            $clog2(NUM_QUEUES * QUEUE_DEPTH) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               operation,
    input  logic [QI_W-1:0]    queue_index,
    input  logic [ID_BITS-1:0] item_id,
    input  logic               urgent,
    output logic               ram_we,
    output logic               ram_re,
    output logic [ADDR_W-1:0]  ram_addr,
    output logic [ENT_W-1:0]   ram_wdata,
    output mqpd_pkg::mqpd_res_t res,
    output logic [CNT_W-1:0]   new_length
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W = CNT_W + 1;

    logic [PTR_W-1:0] head_reg [0:NUM_QUEUES-1];
    logic [CNT_W-1:0] cnt_reg  [0:NUM_QUEUES-1];

    logic              q_ok;
    logic [QI_W-1:0]   q_sel;
    logic [PTR_W-1:0]  head;
    logic [CNT_W-1:0]  count;
    logic [PTR_W-1:0]  head_dec;
    logic [PTR_W-1:0]  head_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  slot;
    logic [PTR_W-1:0]  head_next;
    logic [CNT_W-1:0]  cnt_next;
    logic              upd;
    logic              we_c;
    logic              re_c;

    // Look up the addressed queue
    assign q_ok  = {1'b0, queue_index} < (QI_W + 1)'(NUM_QUEUES);
    assign q_sel = q_ok ? queue_index : '0;
    assign head  = head_reg[q_sel];
    assign count = cnt_reg[q_sel];

    // Wrap positions within the queue's ring
    assign head_dec = (head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head - 1'b1;
    assign head_inc = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    assign tail_sum = SUM_W'(head) + SUM_W'(count);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

    // Decide the outcome of the request
    always_comb
    begin
        res.status = mqpd_pkg::ST_FULL;
        res.taken  = 1'b0;
        new_length = '0;
        slot       = head;
        head_next  = head;
        cnt_next   = count;
        upd        = 1'b0;
        we_c       = 1'b0;
        re_c       = 1'b0;
        if (!q_ok)
        begin
            res.status = (operation == mqpd_pkg::OP_TAKE) ?
                         mqpd_pkg::ST_EMPTY : mqpd_pkg::ST_FULL;
        end
        else
        begin
            unique case (operation)
                mqpd_pkg::OP_ADD:
                begin
                    if (count >= CNT_W'(QUEUE_DEPTH))
                    begin
                        res.status = mqpd_pkg::ST_FULL;
                        new_length = count;
                    end
                    else
                    begin
                        res.status = mqpd_pkg::ST_ADDED;
                        cnt_next   = count + 1'b1;
                        new_length = cnt_next;
                        upd        = 1'b1;
                        we_c       = 1'b1;
                        if (urgent)
                        begin
                            slot      = head_dec;
                            head_next = head_dec;
                        end
                        else
                        begin
                            slot = tail;
                        end
                    end
                end
                mqpd_pkg::OP_TAKE:
                begin
                    if (count == '0)
                    begin
                        res.status = mqpd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res.status = mqpd_pkg::ST_TAKEN;
                        res.taken  = 1'b1;
                        cnt_next   = count - 1'b1;
                        new_length = cnt_next;
                        head_next  = head_inc;
                        upd        = 1'b1;
                        re_c       = 1'b1;
                    end
                end
                default:
                begin
                    res.status = mqpd_pkg::ST_FULL;
                end
            endcase
        end
    end

    // Drive the entry RAM
    assign ram_we    = fire & we_c;
    assign ram_re    = fire & re_c;
    assign ram_addr  = ADDR_W'(ADDR_W'(q_sel) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(slot);
    assign ram_wdata = {urgent, item_id};

    // Update head and fill count of the addressed queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else if (fire && upd)
        begin
            head_reg[q_sel] <= head_next;
            cnt_reg[q_sel]  <= cnt_next;
        end
    end

endmodule

>>> rtl/multi_queue_priority_deque_top.sv
// A request passes through the input, access and result stage registers in turn.
// Throughput: one request per cycle unless out_ready stalls; each request makes at
// most one access to the single-port entry RAM and one update of its queue's head and count.
// Reset: clears all heads, fill counts and pipeline valid flags at once;
// the entry RAM is not cleared and needs no clearing pass.
// Top level of the multi-queue priority deque.
module multi_queue_priority_deque_top #(
    parameter int NUM_QUEUES  = mqpd_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqpd_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = mqpd_pkg::ID_BITS_DEF,
    localparam int QI_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [QI_W-1:0]    queue_index,
    input  logic [ID_BITS-1:0] item_id,
    input  logic               urgent,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [ID_BITS-1:0] taken_id,
    output logic               taken_urgent,
    output logic [CNT_W-1:0]   new_length
);

    localparam int ENT_W  = ID_BITS + 1;
    localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Input stage
    logic               a_valid_reg;
    logic               a_op_reg;
    logic [QI_W-1:0]    a_q_reg;
    logic [ID_BITS-1:0] a_id_reg;
    logic               a_urg_reg;

    // Access stage
    logic                b_valid_reg;
    mqpd_pkg::mqpd_res_t b_res_reg;
    logic [CNT_W-1:0]    b_len_reg;

    // Result stage
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [ID_BITS-1:0] taken_id_reg;
    logic               taken_urgent_reg;
    logic [CNT_W-1:0]   new_length_reg;

    logic                out_free;
    logic                b_move;
    logic                b_free;
    logic                a_move;
    logic                a_free;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ENT_W-1:0]    ram_wdata;
    logic [ENT_W-1:0]    ram_rdata;
    mqpd_pkg::mqpd_res_t ctrl_res;
    logic [CNT_W-1:0]    ctrl_len;

    // Advance each stage when the one after it frees up
    assign out_free = !out_valid_reg || out_ready;
    assign b_move   = b_valid_reg && out_free;
    assign b_free   = !b_valid_reg || out_free;
    assign a_move   = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || b_free;
    assign in_ready = a_free;

    mqpd_ctrl #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (a_move),
        .operation   (a_op_reg),
        .queue_index (a_q_reg),
        .item_id     (a_id_reg),
        .urgent      (a_urg_reg),
        .ram_we      (ram_we),
        .ram_re      (ram_re),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .res         (ctrl_res),
        .new_length  (ctrl_len)
    );

    mqpd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Track stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    // Hold stage payloads until they advance
    always_ff @(posedge clk)
    begin
        if (in_valid && a_free)
        begin
            a_op_reg  <= operation;
            a_q_reg   <= queue_index;
            a_id_reg  <= item_id;
            a_urg_reg <= urgent;
        end
        if (a_move)
        begin
            b_res_reg <= ctrl_res;
            b_len_reg <= ctrl_len;
        end
        if (b_move)
        begin
            status_reg       <= b_res_reg.status;
            taken_id_reg     <= b_res_reg.taken ? ram_rdata[ID_BITS-1:0] : '0;
            taken_urgent_reg <= b_res_reg.taken & ram_rdata[ID_BITS];
            new_length_reg   <= b_len_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign taken_id     = taken_id_reg;
    assign taken_urgent = taken_urgent_reg;
    assign new_length   = new_length_reg;

endmodule

>>> rtl/mqpd_checker.sv
// Port-level assertions for the multi-queue priority deque, bound to the top level.
module mqpd_checker #(
    parameter int QUEUE_DEPTH = mqpd_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = mqpd_pkg::ID_BITS_DEF,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic [ID_BITS-1:0] taken_id,
    input logic               taken_urgent,
    input logic [CNT_W-1:0]   new_length
);

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(taken_id) && $stable(taken_urgent) && $stable(new_length))
        else $error("result changed while stalled");

    // Only a take returns an item
    a_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != mqpd_pkg::ST_TAKEN |->
        taken_id == '0 && !taken_urgent)
        else $error("item fields set without a take");

    // A successful add leaves the queue nonempty and within depth
    a_add_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mqpd_pkg::ST_ADDED |->
        new_length != '0 && new_length <= CNT_W'(QUEUE_DEPTH))
        else $error("bad length after add");

    // A take leaves room in the queue; an empty report leaves it empty
    a_take_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == mqpd_pkg::ST_TAKEN || status == mqpd_pkg::ST_EMPTY) |->
        new_length < CNT_W'(QUEUE_DEPTH) &&
        (status == mqpd_pkg::ST_TAKEN || new_length == '0))
        else $error("bad length after take");

endmodule

bind multi_queue_priority_deque_top mqpd_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
) u_mqpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .taken_id     (taken_id),
    .taken_urgent (taken_urgent),
    .new_length   (new_length)
);
